>>> src/wes_pkg.sv
// shared types and constants for the wave equation stencil step
package wes_pkg;

  // fixed formats of the lattice data
  localparam int VALUE_WIDTH   = 32;
  localparam int FRACTION_BITS = 16;
  localparam int DT_WIDTH      = 16;
  localparam int ENERGY_WIDTH  = 63;

  localparam logic [DT_WIDTH-1:0] TIME_STEP_RESET = DT_WIDTH'(655);

  // shared multiplier operand: wide enough for the laplacian and the phi difference
  localparam int MUL_WIDTH  = VALUE_WIDTH + 2;
  localparam int PROD_WIDTH = 2 * MUL_WIDTH;
  // update sums before saturation
  localparam int SUM_WIDTH  = VALUE_WIDTH + 4;
  // energy add: wide enough for the accumulator and any shifted square
  localparam int EXT_WIDTH  = (PROD_WIDTH > ENERGY_WIDTH) ? PROD_WIDTH : ENERGY_WIDTH + 1;
  localparam int ACC_SUM_WIDTH = EXT_WIDTH + 1;

  localparam logic [ENERGY_WIDTH-1:0] ENERGY_MAX = '1;

  // window fill codes
  typedef enum logic [1:0] {
    FILL_EMPTY = 2'd0,
    FILL_ONE   = 2'd1,
    FILL_TWO   = 2'd2,
    FILL_RUN   = 2'd3
  } fill_t;

  // sequencer states
  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_MV   = 7'b0000010,
    S_ML   = 7'b0000100,
    S_SD   = 7'b0001000,
    S_SQV  = 7'b0010000,
    S_ACC  = 7'b0100000,
    S_OUT  = 7'b1000000
  } state_t;

  // clamp an update sum to the signed value range
  function automatic logic [VALUE_WIDTH-1:0] sat_value(input logic signed [SUM_WIDTH-1:0] x);
    logic signed [SUM_WIDTH-1:0] hi;
    logic signed [SUM_WIDTH-1:0] lo;
    logic [VALUE_WIDTH-1:0]      res;
    hi = $signed({{(SUM_WIDTH-VALUE_WIDTH+1){1'b0}}, {(VALUE_WIDTH-1){1'b1}}});
    lo = ~hi;
    if (x > hi) begin
      res = hi[VALUE_WIDTH-1:0];
    end else if (x < lo) begin
      res = lo[VALUE_WIDTH-1:0];
    end else begin
      res = x[VALUE_WIDTH-1:0];
    end
    return res;
  endfunction

endpackage

>>> src/wave_equation_stencil_step.sv
// top level: one explicit euler step of the 1d wave equation over a streamed lattice
//
// channel  dir  beat contents
// in_      in   tdata[31:0] phi_in, tdata[63:32] velocity_in, tlast last_point
// out_     out  tdata[31:0] phi_out, tdata[63:32] velocity_out,
//               tdata[126:64] energy_total, tdata[127] zero, tlast end_of_lattice
// cfg_     in   data[15:0] time_step (dt, unsigned q0.16), always ready
//
// an interior point is accepted in idle, then steps through the one shared
// 34x34 signed multiplier (v*dt, laplacian*dt, phi difference squared,
// velocity squared, last accumulate) and gives one output beat. the first
// point gives a zero beat at once, the second no beat of its own, and a
// final point adds one more beat for the end-of-lattice result.
// rst_n is synchronous, active low, clears the window and energy and loads
// the reset dt of 655.
// in_tready is high only in idle; a stalled out_tready holds the block in
// the output state with the result beat unchanged.
module wave_equation_stencil_step (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [63:0]  in_tdata,   // phi_in [31:0], velocity_in [63:32]
  input  logic         in_tlast,   // last_point
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [127:0] out_tdata,  // phi_out [31:0], velocity_out [63:32],
                                   // energy_total [126:64], zero [127]
  output logic         out_tlast,  // end_of_lattice
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [15:0]  cfg_data    // time_step
);

  localparam int VW  = wes_pkg::VALUE_WIDTH;
  localparam int MW  = wes_pkg::MUL_WIDTH;
  localparam int PW  = wes_pkg::PROD_WIDTH;
  localparam int SW  = wes_pkg::SUM_WIDTH;
  localparam int EW  = wes_pkg::ENERGY_WIDTH;
  localparam int DW  = wes_pkg::DT_WIDTH;
  localparam int ASW = wes_pkg::ACC_SUM_WIDTH;

  // control state
  wes_pkg::state_t state_r, state_nxt;
  wes_pkg::fill_t  fill_r, fill_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            pt_last_r, pt_last_nxt;
  logic [DW-1:0]   time_step_r, time_step_nxt;
  logic [EW-1:0]   acc_r, acc_nxt;

  // three-point window and previous interior phi
  logic [VW-1:0]   left_r, left_nxt;
  logic [VW-1:0]   center_r, center_nxt;
  logic [VW-1:0]   cvel_r, cvel_nxt;
  logic [VW-1:0]   prev_r, prev_nxt;

  // datapath
  logic [VW-1:0]        pt_phi_r, pt_phi_nxt;
  logic [VW-1:0]        pt_vel_r, pt_vel_nxt;
  logic signed [MW-1:0] lap_r, lap_nxt;
  logic signed [PW-1:0] prod_r, prod_nxt;
  logic [VW-1:0]        new_phi_r, new_phi_nxt;
  logic [VW-1:0]        new_vel_r, new_vel_nxt;

  // output beat
  logic [VW-1:0] out_phi_r, out_phi_nxt;
  logic [VW-1:0] out_vel_r, out_vel_nxt;
  logic [EW-1:0] out_energy_r, out_energy_nxt;
  logic          out_end_r, out_end_nxt;

  // shared multiplier
  logic signed [MW-1:0] mul_a;
  logic signed [MW-1:0] mul_b;
  logic signed [PW-1:0] product;

  logic                 in_fire;
  logic                 out_fire;
  logic [VW-1:0]        in_phi;
  logic [VW-1:0]        in_vel;
  logic signed [MW-1:0] dt_op;
  logic signed [MW-1:0] diff;
  logic signed [PW-1:0] scaled;
  logic signed [SW-1:0] phi_sum;
  logic signed [SW-1:0] vel_sum;
  logic [PW-1:0]        sq_shift;
  logic [ASW-1:0]       acc_sum;
  logic [EW-1:0]        acc_add;

  assign in_phi    = in_tdata[VW-1:0];
  assign in_vel    = in_tdata[2*VW-1:VW];
  assign in_tready = (state_r == wes_pkg::S_IDLE);
  assign in_fire   = in_tvalid & in_tready;
  assign out_fire  = out_valid_r & out_tready;
  assign cfg_ready = 1'b1;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_energy_r, out_vel_r, out_phi_r};
  assign out_tlast  = out_end_r;

  // operands for the shared multiplier
  assign dt_op = $signed({{(MW-DW){1'b0}}, time_step_r});
  assign diff  = $signed({{2{new_phi_r[VW-1]}}, new_phi_r})
               - $signed({{2{prev_r[VW-1]}}, prev_r});

  always_comb begin
    unique case (state_r)
      wes_pkg::S_MV: begin
        mul_a = $signed({{2{cvel_r[VW-1]}}, cvel_r});
        mul_b = dt_op;
      end
      wes_pkg::S_ML: begin
        mul_a = lap_r;
        mul_b = dt_op;
      end
      wes_pkg::S_SD: begin
        mul_a = diff;
        mul_b = diff;
      end
      wes_pkg::S_SQV: begin
        mul_a = $signed({{2{new_vel_r[VW-1]}}, new_vel_r});
        mul_b = $signed({{2{new_vel_r[VW-1]}}, new_vel_r});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign product = mul_a * mul_b;

  // dt products drop the 16 fraction bits of dt, rounding toward minus infinity
  assign scaled  = prod_r >>> DW;
  assign phi_sum = $signed({{(SW-VW){center_r[VW-1]}}, center_r}) + $signed(scaled[SW-1:0]);
  assign vel_sum = $signed({{(SW-VW){cvel_r[VW-1]}}, cvel_r}) + $signed(scaled[SW-1:0]);

  // squares are never negative; drop fraction bits and add with saturation
  assign sq_shift = $unsigned(prod_r) >> wes_pkg::FRACTION_BITS;
  assign acc_sum  = ASW'(sq_shift) + ASW'(acc_r);
  assign acc_add  = (acc_sum > ASW'(wes_pkg::ENERGY_MAX)) ? wes_pkg::ENERGY_MAX
                                                          : acc_sum[EW-1:0];

  always_comb begin
    state_nxt      = state_r;
    fill_nxt       = fill_r;
    out_valid_nxt  = out_valid_r;
    pt_last_nxt    = pt_last_r;
    time_step_nxt  = time_step_r;
    acc_nxt        = acc_r;
    left_nxt       = left_r;
    center_nxt     = center_r;
    cvel_nxt       = cvel_r;
    prev_nxt       = prev_r;
    pt_phi_nxt     = pt_phi_r;
    pt_vel_nxt     = pt_vel_r;
    lap_nxt        = lap_r;
    prod_nxt       = product;
    new_phi_nxt    = new_phi_r;
    new_vel_nxt    = new_vel_r;
    out_phi_nxt    = out_phi_r;
    out_vel_nxt    = out_vel_r;
    out_energy_nxt = out_energy_r;
    out_end_nxt    = out_end_r;

    if (cfg_valid && cfg_ready) begin
      time_step_nxt = cfg_data;
    end

    unique case (state_r)
      wes_pkg::S_IDLE: begin
        if (in_fire) begin
          pt_phi_nxt  = in_phi;
          pt_vel_nxt  = in_vel;
          pt_last_nxt = in_tlast;
          lap_nxt     = $signed({{2{in_phi[VW-1]}}, in_phi})
                      + $signed({{2{left_r[VW-1]}}, left_r})
                      - $signed({center_r[VW-1], center_r, 1'b0});
          unique case (fill_r)
            wes_pkg::FILL_EMPTY: begin
              // start boundary: zero result at once
              center_nxt     = in_phi;
              cvel_nxt       = in_vel;
              fill_nxt       = wes_pkg::FILL_ONE;
              out_phi_nxt    = '0;
              out_vel_nxt    = '0;
              out_energy_nxt = '0;
              out_end_nxt    = 1'b0;
              out_valid_nxt  = 1'b1;
              state_nxt      = wes_pkg::S_OUT;
            end
            wes_pkg::FILL_ONE: begin
              if (in_tlast) begin
                // two-point lattice: only the end result
                out_phi_nxt    = '0;
                out_vel_nxt    = '0;
                out_energy_nxt = acc_r;
                out_end_nxt    = 1'b1;
                out_valid_nxt  = 1'b1;
                pt_last_nxt    = 1'b0;
                left_nxt       = '0;
                center_nxt     = '0;
                cvel_nxt       = '0;
                prev_nxt       = '0;
                acc_nxt        = '0;
                fill_nxt       = wes_pkg::FILL_EMPTY;
                state_nxt      = wes_pkg::S_OUT;
              end else begin
                left_nxt   = center_r;
                center_nxt = in_phi;
                cvel_nxt   = in_vel;
                fill_nxt   = wes_pkg::FILL_TWO;
              end
            end
            default: begin
              state_nxt = wes_pkg::S_MV;
            end
          endcase
        end
      end
      wes_pkg::S_MV: begin
        state_nxt = wes_pkg::S_ML;
      end
      wes_pkg::S_ML: begin
        new_phi_nxt = wes_pkg::sat_value(phi_sum);
        state_nxt   = wes_pkg::S_SD;
      end
      wes_pkg::S_SD: begin
        new_vel_nxt = wes_pkg::sat_value(vel_sum);
        state_nxt   = wes_pkg::S_SQV;
      end
      wes_pkg::S_SQV: begin
        if (fill_r == wes_pkg::FILL_RUN) begin
          acc_nxt = acc_add;
        end
        state_nxt = wes_pkg::S_ACC;
      end
      wes_pkg::S_ACC: begin
        if (fill_r == wes_pkg::FILL_RUN) begin
          acc_nxt = acc_add;
        end
        out_phi_nxt    = new_phi_r;
        out_vel_nxt    = new_vel_r;
        out_energy_nxt = '0;
        out_end_nxt    = 1'b0;
        out_valid_nxt  = 1'b1;
        prev_nxt       = new_phi_r;
        left_nxt       = center_r;
        center_nxt     = pt_phi_r;
        cvel_nxt       = pt_vel_r;
        fill_nxt       = wes_pkg::FILL_RUN;
        state_nxt      = wes_pkg::S_OUT;
      end
      wes_pkg::S_OUT: begin
        if (out_fire) begin
          if (pt_last_r) begin
            // end boundary carries the energy, then the lattice starts over
            out_phi_nxt    = '0;
            out_vel_nxt    = '0;
            out_energy_nxt = acc_r;
            out_end_nxt    = 1'b1;
            pt_last_nxt    = 1'b0;
            left_nxt       = '0;
            center_nxt     = '0;
            cvel_nxt       = '0;
            prev_nxt       = '0;
            acc_nxt        = '0;
            fill_nxt       = wes_pkg::FILL_EMPTY;
          end else begin
            out_valid_nxt = 1'b0;
            state_nxt     = wes_pkg::S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = wes_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= wes_pkg::S_IDLE;
      fill_r      <= wes_pkg::FILL_EMPTY;
      out_valid_r <= 1'b0;
      pt_last_r   <= 1'b0;
      time_step_r <= wes_pkg::TIME_STEP_RESET;
      acc_r       <= '0;
      left_r      <= '0;
      center_r    <= '0;
      cvel_r      <= '0;
      prev_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
      pt_last_r   <= pt_last_nxt;
      time_step_r <= time_step_nxt;
      acc_r       <= acc_nxt;
      left_r      <= left_nxt;
      center_r    <= center_nxt;
      cvel_r      <= cvel_nxt;
      prev_r      <= prev_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pt_phi_r     <= pt_phi_nxt;
    pt_vel_r     <= pt_vel_nxt;
    lap_r        <= lap_nxt;
    prod_r       <= prod_nxt;
    new_phi_r    <= new_phi_nxt;
    new_vel_r    <= new_vel_nxt;
    out_phi_r    <= out_phi_nxt;
    out_vel_r    <= out_vel_nxt;
    out_energy_r <= out_energy_nxt;
    out_end_r    <= out_end_nxt;
  end

endmodule

>>> test/wave_equation_stencil_step_test.sv
// testbench for the wave equation stencil step: streamed lattices checked against a predictor
`timescale 1ns / 1ps

module wave_equation_stencil_step_test;

  localparam int SETTLE_CYCLES    = 16;
  localparam int LONG_HOLD_CYCLES = 300;

  localparam longint VALUE_TOP    = (longint'(1) <<< (wes_pkg::VALUE_WIDTH - 1)) - 1;
  localparam longint VALUE_BOTTOM = -VALUE_TOP - 1;

  localparam logic [31:0] EDGE_VALUES [5] = '{
    32'h7fff_ffff, 32'h8000_0000, 32'h0000_0000, 32'hffff_ffff, 32'h0001_0000
  };

  // opening points, {last_point, velocity_in, phi_in}
  localparam logic [64:0] OPENING_POINTS [17] = '{
    // one-point lattice: start boundary and end beat together
    {1'b1, 32'h8000_0000, 32'h7fff_ffff},
    // two-point lattice: the second point gives only the end beat, energy zero
    {1'b0, 32'h7fff_ffff, 32'h8000_0000},
    {1'b1, 32'hffff_ffff, 32'h0000_0000},
    // phi' clamps high, then low
    {1'b0, 32'h7fff_ffff, 32'h7fff_ffff},
    {1'b0, 32'h7fff_ffff, 32'h7fff_ffff},
    {1'b0, 32'h8000_0000, 32'h8000_0000},
    {1'b0, 32'h8000_0000, 32'h8000_0000},
    {1'b1, 32'h0000_0000, 32'h7fff_ffff},
    // velocity' clamps high, then low, through the laplacian
    {1'b0, 32'h0000_0000, 32'h7fff_ffff},
    {1'b0, 32'h7fff_ffff, 32'h8000_0000},
    {1'b0, 32'h8000_0000, 32'h7fff_ffff},
    {1'b1, 32'h8000_0000, 32'h8000_0000},
    // small negatives: products round toward minus infinity
    {1'b0, 32'hffff_ffff, 32'hffff_ffff},
    {1'b0, 32'hffff_ffff, 32'hffff_ffff},
    {1'b0, 32'h0000_0001, 32'h0000_0000},
    {1'b0, 32'h0001_0000, 32'hffff_0000},
    {1'b1, 32'h8000_0001, 32'h0000_ffff}
  };

  typedef struct {
    logic [wes_pkg::VALUE_WIDTH-1:0]  phi;
    logic [wes_pkg::VALUE_WIDTH-1:0]  velocity;
    logic [wes_pkg::ENERGY_WIDTH-1:0] energy;
    logic                             end_flag;
  } step_result_t;

  // predicts one euler step per lattice point and holds the beats still to come
  class wave_step_tracker;
    logic [wes_pkg::DT_WIDTH-1:0]     dt;
    longint                           left_phi;
    longint                           center_phi;
    longint                           center_vel;
    longint                           prev_new_phi;
    logic [wes_pkg::ENERGY_WIDTH-1:0] energy_acc;
    wes_pkg::fill_t                   fill;
    step_result_t                     pending_results[$];
    int                               mismatches;

    function new();
      dt = wes_pkg::TIME_STEP_RESET;
      mismatches = 0;
      restart_lattice();
    endfunction

    function void restart_lattice();
      left_phi = 0;
      center_phi = 0;
      center_vel = 0;
      prev_new_phi = 0;
      energy_acc = '0;
      fill = wes_pkg::FILL_EMPTY;
    endfunction

    // floor(x * dt / 2^16)
    function longint scale_by_dt(longint x);
      return (x * longint'(dt)) >>> wes_pkg::DT_WIDTH;
    endfunction

    function longint clamp_value(longint x);
      if (x > VALUE_TOP) return VALUE_TOP;
      if (x < VALUE_BOTTOM) return VALUE_BOTTOM;
      return x;
    endfunction

    // floor(x^2 / 2^FRACTION_BITS), clamped to the energy range
    function logic [wes_pkg::ENERGY_WIDTH-1:0] energy_term(longint x);
      logic [63:0]  mag;
      logic [127:0] sq;
      mag = (x < 0) ? 64'(-x) : 64'(x);
      sq = {64'd0, mag} * {64'd0, mag};
      sq = sq >> wes_pkg::FRACTION_BITS;
      if (sq > {65'd0, wes_pkg::ENERGY_MAX}) return wes_pkg::ENERGY_MAX;
      return sq[wes_pkg::ENERGY_WIDTH-1:0];
    endfunction

    function logic [wes_pkg::ENERGY_WIDTH-1:0] energy_add(
        logic [wes_pkg::ENERGY_WIDTH-1:0] a, logic [wes_pkg::ENERGY_WIDTH-1:0] b);
      logic [wes_pkg::ENERGY_WIDTH:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[wes_pkg::ENERGY_WIDTH] ? wes_pkg::ENERGY_MAX : s[wes_pkg::ENERGY_WIDTH-1:0];
    endfunction

    function void queue_result(longint phi, longint vel,
                               logic [wes_pkg::ENERGY_WIDTH-1:0] energy, logic end_flag);
      step_result_t r;
      r.phi = phi[wes_pkg::VALUE_WIDTH-1:0];
      r.velocity = vel[wes_pkg::VALUE_WIDTH-1:0];
      r.energy = energy;
      r.end_flag = end_flag;
      pending_results.push_back(r);
    endfunction

    // an accepted input beat
    function void take_point(logic [wes_pkg::VALUE_WIDTH-1:0] phi_bits,
                             logic [wes_pkg::VALUE_WIDTH-1:0] vel_bits, logic last);
      longint phi;
      longint vel;
      longint lap;
      longint new_phi;
      longint new_vel;
      phi = $signed(phi_bits);
      vel = $signed(vel_bits);
      unique case (fill)
        wes_pkg::FILL_EMPTY: begin
          queue_result(0, 0, '0, 1'b0);
          center_phi = phi;
          center_vel = vel;
          fill = wes_pkg::FILL_ONE;
        end
        wes_pkg::FILL_ONE: begin
          left_phi = center_phi;
          center_phi = phi;
          center_vel = vel;
          fill = wes_pkg::FILL_TWO;
        end
        default: begin
          lap = phi + left_phi - 2 * center_phi;
          new_phi = clamp_value(center_phi + scale_by_dt(center_vel));
          new_vel = clamp_value(center_vel + scale_by_dt(lap));
          // energy only from the second interior point on
          if (fill == wes_pkg::FILL_RUN)
            energy_acc = energy_add(energy_acc,
                                    energy_add(energy_term(new_vel),
                                               energy_term(new_phi - prev_new_phi)));
          queue_result(new_phi, new_vel, '0, 1'b0);
          prev_new_phi = new_phi;
          left_phi = center_phi;
          center_phi = phi;
          center_vel = vel;
          fill = wes_pkg::FILL_RUN;
        end
      endcase
      if (last) begin
        queue_result(0, 0, energy_acc, 1'b1);
        restart_lattice();
      end
    endfunction

    task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch in %s at %0t ns: got %h, expected %h", what, $time, got, want);
      mismatches++;
    endtask

    // an accepted result beat against the oldest expectation
    task check_result(logic [127:0] beat, logic end_flag);
      step_result_t want;
      if (pending_results.size() == 0) begin
        report_mismatch("result beat with nothing pending", beat[63:0], 64'd0);
        return;
      end
      want = pending_results.pop_front();
      if (beat[31:0] !== want.phi)
        report_mismatch("phi_out", 64'(beat[31:0]), 64'(want.phi));
      if (beat[63:32] !== want.velocity)
        report_mismatch("velocity_out", 64'(beat[63:32]), 64'(want.velocity));
      if (beat[126:64] !== want.energy)
        report_mismatch("energy_total", 64'(beat[126:64]), 64'(want.energy));
      if (end_flag !== want.end_flag)
        report_mismatch("end_of_lattice", 64'(end_flag), 64'(want.end_flag));
    endtask
  endclass

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [63:0]  in_tdata;    // phi_in [31:0], velocity_in [63:32]
  logic         in_tlast;    // last_point
  logic         out_tvalid;
  logic         out_tready;
  logic [127:0] out_tdata;   // phi_out [31:0], velocity_out [63:32],
                             // energy_total [126:64], zero [127]
  logic         out_tlast;   // end_of_lattice
  logic         cfg_valid;
  logic         cfg_ready;
  logic [15:0]  cfg_data;    // time_step

  bit hold_request;   // asks the sink for one long hold-off
  bit calm_phase;     // no idling on either side

  wave_step_tracker tracker = new();

  wave_equation_stencil_step DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // everything that crosses a handshake is seen here, with pre-edge values
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) tracker.dt = cfg_data;
      if (in_tvalid && in_tready)
        tracker.take_point(in_tdata[31:0], in_tdata[63:32], in_tlast);
      if (out_tvalid && out_tready) tracker.check_result(out_tdata, out_tlast);
    end
  end

  // result sink: random stall bursts, one long hold-off on request, none when calm
  initial begin
    out_tready <= 1'b0;
    forever begin
      if (hold_request) begin
        out_tready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
        hold_request = 1'b0;
      end else if (!calm_phase && $urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        repeat ($urandom_range(1, 24)) @(posedge clk);
      end
    end
  end

  // mix of full-range, small, edge and near-unit values
  function automatic logic [31:0] lattice_value();
    case ($urandom_range(0, 7))
      0, 1, 2: return $urandom;
      3, 4:    return 32'($urandom_range(0, 32'h0020_0000)) - 32'h0010_0000;
      5:       return EDGE_VALUES[$urandom_range(0, 4)];
      default: return 32'($urandom_range(0, 32'h0002_0000)) - 32'h0001_0000
                      + (($urandom_range(0, 1) == 1) ? 32'h0001_0000 : 32'hffff_0000);
    endcase
  endfunction

  // offer one point and hold it until the block takes it
  task automatic send_point(logic [31:0] phi, logic [31:0] vel, logic last);
    if (!calm_phase && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {vel, phi};
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
  endtask

  // whole lattices, mostly ordinary lengths, some short and some long
  task automatic send_lattices(int target);
    int sent = 0;
    int points;
    while (sent < target) begin
      case ($urandom_range(0, 9))
        0:       points = $urandom_range(1, 2);
        1:       points = $urandom_range(20, 40);
        default: points = $urandom_range(3, 14);
      endcase
      for (int k = 0; k < points; k++)
        send_point(lattice_value(), lattice_value(), k == points - 1);
      sent += points;
    end
  endtask

  // drop valid, let every pending beat drain, then give the block time to go idle
  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (tracker.pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_time_step(logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tlast  <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_data  <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed points at the reset step size
    foreach (OPENING_POINTS[i])
      send_point(OPENING_POINTS[i][31:0], OPENING_POINTS[i][63:32], OPENING_POINTS[i][64]);
    settle();

    // largest step, with the sink holding off so the block backs up
    write_time_step(16'hffff);
    hold_request = 1'b1;
    send_lattices(80);
    settle();

    write_time_step(16'h0000);
    send_lattices(50);
    settle();

    write_time_step(16'h0001);
    send_lattices(50);
    settle();

    write_time_step(16'h8000);
    send_lattices(50);
    settle();

    repeat (2) begin
      write_time_step(16'($urandom));
      send_lattices(40);
      settle();
    end

    // last stretch back at the reset step, both sides running flat out
    write_time_step(wes_pkg::TIME_STEP_RESET);
    calm_phase = 1'b1;
    send_lattices(70);
    settle();

    if (tracker.mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #1_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

>>> wave_equation_stencil_step.f
src/wes_pkg.sv
src/wave_equation_stencil_step.sv
test/wave_equation_stencil_step_test.sv
